@@ rtl/pspa_pkg.sv @@
package pspa_pkg;

  // Default pool depth and the fixed widths of the transaction fields
  localparam int unsigned PoolSizeDef = 16;
  localparam int unsigned ReqW        = 2;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_GET   = 2'd0,
    REQ_DRAIN = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_RESET = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET_LINK,
    S_UNLINK,
    S_WALK
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic fail_empty;   // free or in-use list empty at accept
    logic reset_done;   // reset-all with nothing in use
    logic get_start;
    logic get_finish;
    logic rel_start;    // drain or free: capture slot, read its links
    logic rel_finish;
    logic rel_reject;
    logic walk_start;
    logic walk_step;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
    logic in_use;
  } stat_t;

endpackage

@@ rtl/pspa_ram.sv @@
module pspa_ram import pspa_pkg::*; #(
  parameter int unsigned WIDTH = SlotW,
  parameter int unsigned DEPTH = PoolSizeDef,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/pspa_ctrl.sv @@
module pspa_ctrl import pspa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ReqW-1:0] req_type_i,
  input  stat_t           stat_i,
  output cmd_t            cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;
  req_e   req;

  assign req    = req_e'(req_type_i);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req)
            REQ_GET:   state_d = stat_i.full  ? S_IDLE : S_GET_LINK;
            REQ_DRAIN: state_d = stat_i.empty ? S_IDLE : S_UNLINK;
            REQ_FREE:  state_d = S_UNLINK;
            REQ_RESET: state_d = stat_i.empty ? S_IDLE : S_WALK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_GET_LINK: state_d = S_IDLE;
      S_UNLINK:   state_d = S_IDLE;
      S_WALK:     state_d = stat_i.last ? S_IDLE : S_WALK;
      default:    state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req)
            REQ_GET: begin
              cmd_o.fail_empty = stat_i.full;
              cmd_o.get_start  = !stat_i.full;
            end
            REQ_DRAIN: begin
              cmd_o.fail_empty = stat_i.empty;
              cmd_o.rel_start  = !stat_i.empty;
            end
            REQ_FREE: cmd_o.rel_start = 1'b1;
            REQ_RESET: begin
              cmd_o.reset_done = stat_i.empty;
              cmd_o.walk_start = !stat_i.empty;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      S_GET_LINK: cmd_o.get_finish = 1'b1;
      S_UNLINK: begin
        cmd_o.rel_finish = stat_i.in_use;
        cmd_o.rel_reject = !stat_i.in_use;
      end
      S_WALK:  cmd_o.walk_step = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/pspa_dp.sv @@
module pspa_dp import pspa_pkg::*; #(
  parameter int unsigned POOL_SIZE = PoolSizeDef,
  localparam int unsigned IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
  localparam int unsigned CntW = $clog2(POOL_SIZE + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [SlotW-1:0]   slot_i,
  output stat_t              stat_o,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_out_o,
  output logic [CountW-1:0]  in_use_count_o
);

  logic [IdxW-1:0] free_top_q, free_top_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] mark_q, mark_d;   // slots below the mark never left the pool
  logic            valid_q, valid_d;

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, s_q, s_d;
  logic            fresh_q, fresh_d, chk_q, chk_d, range_q, range_d;
  status_e         st_q, st_d;
  logic [IdxW-1:0] rslot_q, rslot_d;
  logic [CntW-1:0] rcnt_q, rcnt_d;

  logic            link_we, flag_we, next_we, prev_we;
  logic [IdxW-1:0] link_rd, next_rd, prev_rd;
  logic [IdxW-1:0] flag_waddr, next_waddr, prev_waddr, np_raddr;
  logic [IdxW-1:0] next_wdata, prev_wdata, slot_idx;
  logic [0:0]      flag_wdata, flag_rd;
  logic            empty, multi, top_fresh, reply;
  req_e            req;

  assign req       = req_e'(req_type_i);
  assign slot_idx  = IdxW'(slot_i);
  assign empty     = (total_q == '0);
  assign multi     = (total_q > CntW'(1));
  assign top_fresh = (CntW'(free_top_q) < mark_q);

  assign stat_o.full   = (total_q == CntW'(POOL_SIZE));
  assign stat_o.empty  = empty;
  assign stat_o.last   = (total_q == CntW'(1));
  assign stat_o.in_use = !chk_q || (range_q && (CntW'(s_q) >= mark_q) && flag_rd[0]);

  // memory ports
  assign link_we    = cmd_i.rel_finish || cmd_i.walk_step;
  assign flag_we    = cmd_i.get_start || cmd_i.rel_finish || cmd_i.walk_step;
  assign flag_waddr = cmd_i.get_start ? free_top_q : s_q;
  assign flag_wdata = cmd_i.get_start;
  assign next_we    = (cmd_i.get_start && !empty) ||
                      (cmd_i.rel_finish && multi && (s_q != head_q));
  assign next_waddr = cmd_i.get_start ? tail_q : prev_rd;
  assign next_wdata = cmd_i.get_start ? free_top_q : next_rd;
  assign prev_we    = (cmd_i.get_start && !empty) ||
                      (cmd_i.rel_finish && multi && (s_q != tail_q));
  assign prev_waddr = cmd_i.get_start ? free_top_q : next_rd;
  assign prev_wdata = cmd_i.get_start ? tail_q : prev_rd;
  assign np_raddr   = cmd_i.walk_step ? next_rd :
                      ((req == REQ_FREE) ? slot_idx : head_q);

  pspa_ram #(.WIDTH(IdxW), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(s_q), .wdata_i(free_top_q),
    .raddr_i(free_top_q), .rdata_o(link_rd)
  );

  pspa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_flag_ram (
    .clk_i, .we_i(flag_we), .waddr_i(flag_waddr), .wdata_i(flag_wdata),
    .raddr_i(slot_idx), .rdata_o(flag_rd)
  );

  pspa_ram #(.WIDTH(IdxW), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(np_raddr), .rdata_o(next_rd)
  );

  pspa_ram #(.WIDTH(IdxW), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(np_raddr), .rdata_o(prev_rd)
  );

  always_comb begin
    free_top_d = free_top_q;
    total_d    = total_q;
    mark_d     = mark_q;
    head_d     = head_q;
    tail_d     = tail_q;
    s_d        = s_q;
    fresh_d    = fresh_q;
    chk_d      = chk_q;
    range_d    = range_q;
    st_d       = st_q;
    rslot_d    = rslot_q;
    rcnt_d     = rcnt_q;
    reply      = 1'b0;

    if (cmd_i.fail_empty) begin
      reply   = 1'b1;
      st_d    = ST_EMPTY;
      rslot_d = '0;
      rcnt_d  = total_q;
    end
    if (cmd_i.reset_done) begin
      reply   = 1'b1;
      st_d    = ST_OK;
      rslot_d = '0;
      rcnt_d  = '0;
    end
    if (cmd_i.get_start) begin
      s_d     = free_top_q;
      fresh_d = top_fresh;
      if (top_fresh) begin
        mark_d = CntW'(free_top_q);
      end
      if (empty) begin
        head_d = free_top_q;
      end
      tail_d  = free_top_q;
      total_d = total_q + CntW'(1);
    end
    if (cmd_i.get_finish) begin
      // a never-linked slot chains to the next lower one
      if (fresh_q) begin
        free_top_d = (s_q == '0) ? '0 : (s_q - IdxW'(1));
      end else begin
        free_top_d = link_rd;
      end
      reply   = 1'b1;
      st_d    = ST_OK;
      rslot_d = s_q;
      rcnt_d  = total_q;
    end
    if (cmd_i.rel_start) begin
      chk_d   = (req == REQ_FREE);
      s_d     = (req == REQ_FREE) ? slot_idx : head_q;
      range_d = (req != REQ_FREE) || (32'(slot_i) < POOL_SIZE);
    end
    if (cmd_i.rel_finish) begin
      if (multi) begin
        if (s_q == head_q) begin
          head_d = next_rd;
        end
        if (s_q == tail_q) begin
          tail_d = prev_rd;
        end
      end
      free_top_d = s_q;
      total_d    = total_q - CntW'(1);
      reply      = 1'b1;
      st_d       = ST_OK;
      rslot_d    = s_q;
      rcnt_d     = total_q - CntW'(1);
    end
    if (cmd_i.rel_reject) begin
      reply   = 1'b1;
      st_d    = ST_NOT_USED;
      rslot_d = '0;
      rcnt_d  = total_q;
    end
    if (cmd_i.walk_start) begin
      s_d = head_q;
    end
    if (cmd_i.walk_step) begin
      free_top_d = s_q;
      total_d    = total_q - CntW'(1);
      s_d        = next_rd;
      if (total_q == CntW'(1)) begin
        reply   = 1'b1;
        st_d    = ST_OK;
        rslot_d = '0;
        rcnt_d  = '0;
      end
    end
    valid_d = reply;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q <= IdxW'(POOL_SIZE - 1);
      total_q    <= '0;
      mark_q     <= CntW'(POOL_SIZE);
      valid_q    <= 1'b0;
    end else begin
      free_top_q <= free_top_d;
      total_q    <= total_d;
      mark_q     <= mark_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    tail_q  <= tail_d;
    s_q     <= s_d;
    fresh_q <= fresh_d;
    chk_q   <= chk_d;
    range_q <= range_d;
    st_q    <= st_d;
    rslot_q <= rslot_d;
    rcnt_q  <= rcnt_d;
  end

  assign done_o         = valid_q;
  assign status_o       = st_q;
  assign slot_out_o     = SlotW'(rslot_q);
  assign in_use_count_o = CountW'(rcnt_q);

endmodule

@@ rtl/packet_slot_pool_allocator.sv @@
// Packet slot pool allocator. Keeps POOL_SIZE slots on a last-in-first-out
// free stack and an oldest-first in-use list, and serves get, drain, free and
// reset-all requests. A transaction is taken at a clock edge with start high
// and busy low; exactly one result follows, shown for a single cycle with
// done_o high. The receiver cannot stall: done_o is a strobe and must be
// captured in that cycle. Get, drain and free pass from accept through the
// GET_LINK or UNLINK state to the registered result, and the next one can
// be taken in the result cycle, not before; this is set by the registered
// read of the link memories (read at accept, used in GET_LINK or written
// back in UNLINK). Get on a full pool and drain or reset-all with nothing
// in use answer in the cycle after accept; else reset-all walks the in-use
// list one slot per cycle through the next-pointer memory. No clearing pass
// is needed after reset; the block is ready at once.
module packet_slot_pool_allocator import pspa_pkg::*; #(
  parameter int unsigned POOL_SIZE = PoolSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [SlotW-1:0]   slot_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_out_o,
  output logic [CountW-1:0]  in_use_count_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: sequences each transaction and the reset-all walk
  pspa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .req_type_i,
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Datapath: list pointers, link memories and the result register.
  // Slots below the fill mark were never handed out, so their free link is
  // implied (next lower slot) and their in-use flag reads as clear.
  pspa_dp #(.POOL_SIZE(POOL_SIZE)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .req_type_i,
    .slot_i,
    .stat_o     (stat),
    .done_o,
    .status_o,
    .slot_out_o,
    .in_use_count_o
  );

endmodule

@@ rtl/pspa_checker.sv @@
module pspa_checker import pspa_pkg::*; #(
  parameter int unsigned POOL_SIZE = PoolSizeDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [ReqW-1:0]    req_type_i,
  input logic [SlotW-1:0]   slot_i,
  input logic               done_o,
  input logic [StatusW-1:0] status_o,
  input logic [SlotW-1:0]   slot_out_o,
  input logic [CountW-1:0]  in_use_count_o
);

  // a result always lands with the block ready for the next transaction
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  // an accepted transaction either answers at once or holds busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy)) else $error("transaction lost");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (slot_out_o == '0))
    else $error("slot not zero on failed request");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |->
      ((in_use_count_o == '0) || (in_use_count_o == CountW'(POOL_SIZE))))
    else $error("list empty reported with pool neither empty nor full");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start && !busy) && !$past(busy)) |-> !done_o)
    else $error("result without a transaction");

endmodule

bind packet_slot_pool_allocator pspa_checker #(.POOL_SIZE(POOL_SIZE)) u_pspa_checker (.*);

@@ sim/tb.sv @@
module tb;
  import pspa_pkg::*;

  // Clocking and run limits
  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned RandomItems  = 1500;
  localparam int unsigned DrainCycles  = 24;      // > longest reset-all walk
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned NumSlots     = PoolSizeDef;
  localparam int unsigned NumRows      = 12;

  // One expected reply, field for field as the block presents it
  typedef struct packed {
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic [CountW-1:0]   count;
  } reply_t;

  // Directed stimulus row: a request, how often to issue it, and, where the
  // answer is obvious, the reply typed in by hand
  typedef struct packed {
    req_e                req;
    logic [SlotW-1:0]    slot;
    logic [4:0]          reps;
    logic                fixed;
    status_e             status;
    logic [SlotW-1:0]    slot_out;
    logic [CountW-1:0]   count;
  } step_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [ReqW-1:0]    req_type_i;
  logic [SlotW-1:0]   slot_i;
  logic               done_o;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   slot_out_o;
  logic [CountW-1:0]  in_use_count_o;

  // Shadow copy of the pool: free stack with links, in-use list both ways
  logic [SlotW-1:0]   fl_link    [NumSlots];
  logic [SlotW-1:0]   ul_next    [NumSlots];
  logic [SlotW-1:0]   ul_prev    [NumSlots];
  logic               slot_taken [NumSlots];
  logic [SlotW-1:0]   fl_top;
  logic [SlotW-1:0]   ul_head;
  logic [SlotW-1:0]   ul_tail;
  int unsigned        ul_total;

  reply_t             expected_replies [$];
  int unsigned        mismatches  = 0;
  int unsigned        cycle_count = 0;

  // Directed part. Hand-typed replies cover the start from reset, the
  // full and empty pool and the not-in-use cases; the rest go through the
  // shadow model.
  step_row_t dir_rows [NumRows] = '{
    '{REQ_DRAIN, 4'd0,  5'd1,  1'b1, ST_EMPTY,    4'd0,  5'd0},  // nothing in use
    '{REQ_FREE,  4'd15, 5'd1,  1'b1, ST_NOT_USED, 4'd0,  5'd0},  // top slot idle
    '{REQ_RESET, 4'd9,  5'd1,  1'b1, ST_OK,       4'd0,  5'd0},  // reset-all, empty
    '{REQ_GET,   4'd0,  5'd1,  1'b1, ST_OK,       4'd15, 5'd1},  // highest first
    '{REQ_FREE,  4'd0,  5'd1,  1'b1, ST_NOT_USED, 4'd0,  5'd1},
    '{REQ_FREE,  4'd15, 5'd1,  1'b1, ST_OK,       4'd15, 5'd0},
    '{REQ_GET,   4'd5,  5'd16, 1'b0, ST_OK,       4'd0,  5'd0},  // fill the pool
    '{REQ_GET,   4'd15, 5'd1,  1'b1, ST_EMPTY,    4'd0,  5'd16}, // pool exhausted
    '{REQ_FREE,  4'd0,  5'd1,  1'b1, ST_OK,       4'd0,  5'd15}, // lowest slot
    '{REQ_DRAIN, 4'd7,  5'd1,  1'b0, ST_OK,       4'd0,  5'd0},
    '{REQ_RESET, 4'd0,  5'd1,  1'b1, ST_OK,       4'd0,  5'd0},  // long walk
    '{REQ_GET,   4'd10, 5'd2,  1'b0, ST_OK,       4'd0,  5'd0}
  };

  packet_slot_pool_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .slot_i         (slot_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_out_o     (slot_out_o),
    .in_use_count_o (in_use_count_o)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  // Applies one transaction to the shadow pool and returns the reply the
  // block owes for it
  function automatic reply_t predict_pool_reply(req_e req, logic [SlotW-1:0] sl);
    reply_t           r;
    logic [SlotW-1:0] s;
    int unsigned      n;
    r.status = ST_OK;
    r.slot   = '0;
    case (req)
      REQ_GET: begin
        if (ul_total >= NumSlots) begin
          r.status = ST_EMPTY;
        end else begin
          s = fl_top;
          fl_top = fl_link[s];
          slot_taken[s] = 1'b1;
          if (ul_total == 0) begin
            ul_head = s;
          end else begin
            ul_next[ul_tail] = s;
            ul_prev[s] = ul_tail;
          end
          ul_tail = s;
          ul_total++;
          r.slot = s;
        end
      end
      REQ_DRAIN, REQ_FREE: begin
        if (req == REQ_DRAIN && ul_total == 0) begin
          r.status = ST_EMPTY;
        end else if (req == REQ_FREE && !slot_taken[sl]) begin
          r.status = ST_NOT_USED;
        end else begin
          s = (req == REQ_DRAIN) ? ul_head : sl;
          // unlink from the in-use list; a lone entry needs no pointer work
          if (ul_total > 1) begin
            if (s == ul_head) ul_head = ul_next[s];
            else ul_next[ul_prev[s]] = ul_next[s];
            if (s == ul_tail) ul_tail = ul_prev[s];
            else ul_prev[ul_next[s]] = ul_prev[s];
          end
          ul_total--;
          fl_link[s] = fl_top;
          fl_top = s;
          slot_taken[s] = 1'b0;
          r.slot = s;
        end
      end
      default: begin
        // reset-all: oldest goes onto the free stack first
        n = ul_total;
        while (n > 0) begin
          s = ul_head;
          if (n > 1) ul_head = ul_next[s];
          fl_link[s] = fl_top;
          fl_top = s;
          slot_taken[s] = 1'b0;
          n--;
        end
        ul_total = 0;
      end
    endcase
    r.count = CountW'(ul_total);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Drives one transaction. Called at a rising edge; returns at the edge
  // where the block took it. The sender may first sit idle with start low,
  // for a random stretch drawn against idle_pct.
  task automatic issue_request(input req_e req, input logic [SlotW-1:0] sl,
                               input int unsigned idle_pct, input bit use_fixed,
                               input reply_t fixed_reply);
    reply_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      req_type_i <= ReqW'($urandom_range(3));
      slot_i     <= SlotW'($urandom_range(15));
      @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    slot_i     <= sl;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    // taken at this edge: keep the shadow pool in step even for typed rows
    predicted = predict_pool_reply(req, sl);
    expected_replies.push_back(use_fixed ? fixed_reply : predicted);
  endtask

  // Sender holds off until every outstanding reply is back
  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every strobe must match the oldest pending transaction
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result with no transaction pending, slot", slot_out_o, 0);
      end else begin
        want = expected_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (slot_out_o !== want.slot)
          report_mismatch("slot_out", slot_out_o, want.slot);
        if (in_use_count_o !== want.count)
          report_mismatch("in_use_count", in_use_count_o, want.count);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d replies outstanding",
               cycle_count, expected_replies.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    reply_t           row_reply;
    req_e             req;
    logic [SlotW-1:0] sl;
    logic [SlotW-1:0] taken_list [$];
    int unsigned      pick;
    int unsigned      idle_pct;
    bit               filling;

    start       = 1'b0;
    req_type_i  = '0;
    slot_i      = '0;
    rst_ni      = 1'b0;

    // shadow pool out of reset: each slot links to the one below, top is
    // the highest slot, nothing in use
    for (int i = 0; i < NumSlots; i++) begin
      fl_link[i]    = (i == 0) ? '0 : SlotW'(i - 1);
      ul_next[i]    = '0;
      ul_prev[i]    = '0;
      slot_taken[i] = 1'b0;
    end
    fl_top   = SlotW'(NumSlots - 1);
    ul_head  = '0;
    ul_tail  = '0;
    ul_total = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[r]) begin
      row_reply.status = dir_rows[r].status;
      row_reply.slot   = dir_rows[r].slot_out;
      row_reply.count  = dir_rows[r].count;
      for (int k = 0; k < dir_rows[r].reps; k++)
        issue_request(dir_rows[r].req, dir_rows[r].slot, 36, dir_rows[r].fixed, row_reply);
    end
    wait_for_quiet();

    // Random part. Stretches that lean towards filling the pool alternate
    // with stretches that lean towards emptying it, so both the full and
    // the empty corner come round often. Most frees name a slot in use.
    filling = 1'b1;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      idle_pct = (n < RandomItems / 3) ? 36 : (n < 2 * RandomItems / 3) ? 59 : 0;
      if (n % 60 == 0) filling = ~filling;
      if (n % 500 == 250 || $urandom_range(99) < 2) wait_for_quiet();

      pick = $urandom_range(99);
      sl   = SlotW'($urandom_range(15));
      if (filling)
        req = (pick < 72) ? REQ_GET : (pick < 77) ? REQ_DRAIN :
              (pick < 97) ? REQ_FREE : REQ_RESET;
      else
        req = (pick < 20) ? REQ_GET : (pick < 50) ? REQ_DRAIN :
              (pick < 98) ? REQ_FREE : REQ_RESET;

      if (req == REQ_FREE && $urandom_range(99) < 85) begin
        taken_list.delete();
        for (int i = 0; i < NumSlots; i++)
          if (slot_taken[i]) taken_list.push_back(SlotW'(i));
        if (taken_list.size() != 0)
          sl = taken_list[$urandom_range(taken_list.size() - 1)];
      end
      issue_request(req, sl, idle_pct, 1'b0, row_reply);
    end

    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
